/* design/p1t_pkg.sv */
`timescale 1ns / 1ps
// Shared types and widths for the P1 triangle element stiffness block.
// Used by every module of the block; depends on nothing.
package p1t_pkg;

  // Field widths
  localparam int COORD_W     = 24;
  localparam int NODE_W      = 16;
  localparam int ENTRY_W     = 48;
  localparam int ENTRY_FRAC  = 16;
  localparam int EPS_REL_W   = 16;
  localparam int SCALE_W     = 32;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

  // Internal arithmetic widths
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int DET_W    = PROD_W + 1;
  localparam int MAG_W    = DET_W;
  localparam int EPS_W    = EPS_REL_W + SCALE_W;
  localparam int EPS_FRAC = 24;
  localparam int HALF_SH  = EPS_FRAC - ENTRY_FRAC;
  localparam int DEN_SH   = HALF_SH + 1;
  localparam int DEN_W    = MAG_W + DEN_SH;
  localparam int NUM_W    = EPS_W + MAG_W + 1;
  localparam int Q_W      = ENTRY_W;
  localparam int R_W      = DEN_W + 1;

  // Partial products of eps * |n|
  localparam int EPS_LO_W = EPS_W / 2;
  localparam int N_LO_W   = (MAG_W + 1) / 2;
  localparam int PP_W     = EPS_LO_W + N_LO_W + 1;
  localparam int S_W      = EPS_LO_W + MAG_W;

  // Divider layout
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = Q_W / DIV_STEPS;

  localparam logic [Q_W-1:0] MAX_POS = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] MAX_NEG = {1'b1, {(Q_W-1){1'b0}}};

  // Local vertex index of the last row and column
  localparam logic [1:0] LAST_IDX = 2'd2;

  typedef struct packed {
    logic [NODE_W-1:0]         node_a;
    logic [NODE_W-1:0]         node_b;
    logic [NODE_W-1:0]         node_c;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [EPS_REL_W-1:0]      eps_relative;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]         row_node;
    logic [NODE_W-1:0]         col_node;
    logic signed [ENTRY_W-1:0] entry_value;
    logic                      degenerate;
    logic                      last_entry;
  } out_item_t;

  // Per-triangle data handed from the front end to the expander
  typedef struct packed {
    logic [2:0][NODE_W-1:0] node;
    logic [2:0][DIFF_W-1:0] gb;
    logic [2:0][DIFF_W-1:0] gc;
    logic [EPS_W-1:0]       eps;
    logic [MAG_W-1:0]       dmag;
    logic                   degen;
  } tri_t;

  // One matrix entry to compute
  typedef struct packed {
    logic [NODE_W-1:0] row;
    logic [NODE_W-1:0] col;
    logic              last;
    logic              degen;
    logic [DIFF_W-1:0] gbi;
    logic [DIFF_W-1:0] gbj;
    logic [DIFF_W-1:0] gci;
    logic [DIFF_W-1:0] gcj;
    logic [EPS_W-1:0]  eps;
    logic [MAG_W-1:0]  dmag;
  } job_t;

  // Tag that rides along with an entry through the back pipeline
  typedef struct packed {
    logic [NODE_W-1:0] row;
    logic [NODE_W-1:0] col;
    logic              degen;
    logic              last;
    logic              neg;
  } tag_t;

endpackage

/* design/p1t_front.sv */
`timescale 1ns / 1ps
// Triangle front end: edge differences, eps product, determinant and its magnitude.
// Three register stages with local stall; depends on p1t_pkg.
module p1t_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [p1t_pkg::SCALE_W-1:0] scale_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  p1t_pkg::in_item_t         in_item_i,
  output logic                      tri_valid_o,
  input  logic                      tri_ready_i,
  output p1t_pkg::tri_t             tri_o
);
  import p1t_pkg::*;

  typedef struct packed {
    logic [2:0][NODE_W-1:0] node;
    logic [2:0][DIFF_W-1:0] gb;
    logic [2:0][DIFF_W-1:0] gc;
    logic [EPS_W-1:0]       eps;
  } grad_t;

  logic  v1_q, v2_q, v3_q;
  logic  en1, en2, en3;
  grad_t s1_q, s2_q;
  logic signed [PROD_W-1:0] pa_q, pb_q;
  tri_t  s3_q;

  logic signed [DIFF_W-1:0] gb1_s, gb2_s, gc1_s, gc2_s;
  logic signed [DET_W-1:0]  det;

  // Stage enables: a stage moves when it is empty or the next one moves
  assign en3 = !v3_q || tri_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage 1: gradient differences and eps_relative * scale
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q.node[0] <= in_item_i.node_a;
      s1_q.node[1] <= in_item_i.node_b;
      s1_q.node[2] <= in_item_i.node_c;
      s1_q.gb[0]   <= DIFF_W'(in_item_i.by_coord) - DIFF_W'(in_item_i.cy);
      s1_q.gc[0]   <= DIFF_W'(in_item_i.cx) - DIFF_W'(in_item_i.bx);
      s1_q.gb[1]   <= DIFF_W'(in_item_i.cy) - DIFF_W'(in_item_i.ay);
      s1_q.gc[1]   <= DIFF_W'(in_item_i.ax) - DIFF_W'(in_item_i.cx);
      s1_q.gb[2]   <= DIFF_W'(in_item_i.ay) - DIFF_W'(in_item_i.by_coord);
      s1_q.gc[2]   <= DIFF_W'(in_item_i.bx) - DIFF_W'(in_item_i.ax);
      s1_q.eps     <= EPS_W'(in_item_i.eps_relative) * EPS_W'(scale_i);
    end
  end

  assign gb1_s = signed'(s1_q.gb[1]);
  assign gb2_s = signed'(s1_q.gb[2]);
  assign gc1_s = signed'(s1_q.gc[1]);
  assign gc2_s = signed'(s1_q.gc[2]);

  // Stage 2: the two determinant products
  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_q <= s1_q;
      pa_q <= gc2_s * gb1_s;
      pb_q <= gc1_s * gb2_s;
    end
  end

  assign det = DET_W'(pa_q) - DET_W'(pb_q);

  // Stage 3: determinant magnitude and degenerate flag
  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_q.node  <= s2_q.node;
      s3_q.gb    <= s2_q.gb;
      s3_q.gc    <= s2_q.gc;
      s3_q.eps   <= s2_q.eps;
      s3_q.dmag  <= det[DET_W-1] ? MAG_W'(-det) : MAG_W'(det);
      s3_q.degen <= (det == '0);
    end
  end

  assign tri_valid_o = v3_q;
  assign tri_o       = s3_q;

endmodule

/* design/p1t_expand.sv */
`timescale 1ns / 1ps
// Entry sequencer: holds one triangle and issues its nine entries in row-major order.
// Depends on p1t_pkg.
module p1t_expand (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          tri_valid_i,
  output logic          tri_ready_o,
  input  p1t_pkg::tri_t tri_i,
  output logic          job_valid_o,
  output p1t_pkg::job_t job_o
);
  import p1t_pkg::*;

  logic       held_q;
  logic [1:0] row_q, col_q;
  tri_t       tri_q;
  logic       is_last, issue, load;

  assign is_last     = (row_q == LAST_IDX) && (col_q == LAST_IDX);
  assign issue       = held_q && adv_i;
  assign tri_ready_o = adv_i && (!held_q || is_last);
  assign load        = tri_valid_i && tri_ready_o;

  // Step row and column; reload when the last entry leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      row_q  <= '0;
      col_q  <= '0;
    end else if (load) begin
      held_q <= 1'b1;
      row_q  <= '0;
      col_q  <= '0;
    end else if (issue) begin
      if (is_last) begin
        held_q <= 1'b0;
      end else if (col_q == LAST_IDX) begin
        col_q <= '0;
        row_q <= row_q + 2'd1;
      end else begin
        col_q <= col_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) tri_q <= tri_i;
  end

  assign job_valid_o = held_q;
  assign job_o.row   = tri_q.node[row_q];
  assign job_o.col   = tri_q.node[col_q];
  assign job_o.last  = is_last;
  assign job_o.degen = tri_q.degen;
  assign job_o.gbi   = tri_q.gb[row_q];
  assign job_o.gbj   = tri_q.gb[col_q];
  assign job_o.gci   = tri_q.gc[row_q];
  assign job_o.gcj   = tri_q.gc[col_q];
  assign job_o.eps   = tri_q.eps;
  assign job_o.dmag  = tri_q.dmag;

endmodule

/* design/p1t_entry.sv */
`timescale 1ns / 1ps
// Entry numerator path: gradient dot product, eps multiply in partial products,
// rounding offset and divisor. Five stages on the global advance; depends on p1t_pkg.
module p1t_entry (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      job_valid_i,
  input  p1t_pkg::job_t             job_i,
  output logic                      num_valid_o,
  output logic [p1t_pkg::NUM_W-1:0] num_o,
  output logic [p1t_pkg::DEN_W-1:0] den_o,
  output p1t_pkg::tag_t             tag_o
);
  import p1t_pkg::*;

  logic [4:0] v_q;
  tag_t       tag1_q, tag2_q, tag3_q, tag4_q, tag5_q;
  logic [EPS_W-1:0] eps1_q, eps2_q;
  logic [MAG_W-1:0] dmag1_q, dmag2_q, dmag3_q, dmag4_q;
  logic signed [PROD_W-1:0] pb1_q, pc1_q;
  logic [MAG_W-1:0] nmag2_q;
  logic [PP_W-1:0]  pp00_q, pp01_q, pp10_q, pp11_q;
  logic [S_W-1:0]   s0_q, s1_q;
  logic [NUM_W-1:0] num5_q;
  logic [DEN_W-1:0] den5_q;

  logic signed [DIFF_W-1:0] gbi_s, gbj_s, gci_s, gcj_s;
  logic signed [DET_W-1:0]  nsum;

  assign gbi_s = signed'(job_i.gbi);
  assign gbj_s = signed'(job_i.gbj);
  assign gci_s = signed'(job_i.gci);
  assign gcj_s = signed'(job_i.gcj);
  assign nsum  = DET_W'(pb1_q) + DET_W'(pc1_q);

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[3:0], job_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // Stage 1: gradient products
      tag1_q.row   <= job_i.row;
      tag1_q.col   <= job_i.col;
      tag1_q.degen <= job_i.degen;
      tag1_q.last  <= job_i.last;
      tag1_q.neg   <= 1'b0;
      pb1_q        <= gbi_s * gbj_s;
      pc1_q        <= gci_s * gcj_s;
      eps1_q       <= job_i.eps;
      dmag1_q      <= job_i.dmag;
      // Stage 2: dot product split into sign and magnitude
      tag2_q       <= '{row: tag1_q.row, col: tag1_q.col, degen: tag1_q.degen,
                        last: tag1_q.last, neg: nsum[DET_W-1]};
      nmag2_q      <= nsum[DET_W-1] ? MAG_W'(-nsum) : MAG_W'(nsum);
      eps2_q       <= eps1_q;
      dmag2_q      <= dmag1_q;
      // Stage 3: four partial products of eps * |n|
      tag3_q       <= tag2_q;
      pp00_q <= PP_W'(eps2_q[EPS_LO_W-1:0]) * PP_W'(nmag2_q[N_LO_W-1:0]);
      pp01_q <= PP_W'(eps2_q[EPS_LO_W-1:0]) * PP_W'(nmag2_q[MAG_W-1:N_LO_W]);
      pp10_q <= PP_W'(eps2_q[EPS_W-1:EPS_LO_W]) * PP_W'(nmag2_q[N_LO_W-1:0]);
      pp11_q <= PP_W'(eps2_q[EPS_W-1:EPS_LO_W]) * PP_W'(nmag2_q[MAG_W-1:N_LO_W]);
      dmag3_q      <= dmag2_q;
      // Stage 4: combine partial products by eps half
      tag4_q       <= tag3_q;
      s0_q         <= S_W'(pp00_q) + (S_W'(pp01_q) << N_LO_W);
      s1_q         <= S_W'(pp10_q) + (S_W'(pp11_q) << N_LO_W);
      dmag4_q      <= dmag3_q;
      // Stage 5: full numerator with rounding offset, and divisor 2|D|
      tag5_q       <= tag4_q;
      num5_q       <= NUM_W'(s0_q) + (NUM_W'(s1_q) << EPS_LO_W)
                      + (NUM_W'(dmag4_q) << HALF_SH);
      den5_q       <= DEN_W'(dmag4_q) << DEN_SH;
    end
  end

  assign num_valid_o = v_q[4];
  assign num_o       = num5_q;
  assign den_o       = den5_q;
  assign tag_o       = tag5_q;

endmodule

/* design/p1t_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: a few quotient bits per stage, overflow flag when
// the quotient does not fit the entry width. Depends on p1t_pkg.
module p1t_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  logic [p1t_pkg::NUM_W-1:0] num_i,
  input  logic [p1t_pkg::DEN_W-1:0] den_i,
  input  p1t_pkg::tag_t             tag_i,
  output logic                      valid_o,
  output logic [p1t_pkg::Q_W-1:0]   quot_o,
  output logic                      ovf_o,
  output p1t_pkg::tag_t             tag_o
);
  import p1t_pkg::*;

  typedef struct packed {
    logic [R_W-1:0]   rem;
    logic [Q_W-1:0]   lq;   // numerator bits still to use, quotient shifted in below
    logic [DEN_W-1:0] den;
    logic             ovf;
    tag_t             tag;
  } dstage_t;

  function automatic dstage_t div_step(dstage_t s);
    dstage_t        t;
    logic [R_W-1:0] r;
    t = s;
    for (int k = 0; k < DIV_STEPS; k++) begin
      r = {t.rem[R_W-2:0], t.lq[Q_W-1]};
      if (r >= R_W'(t.den)) begin
        t.rem = r - R_W'(t.den);
        t.lq  = {t.lq[Q_W-2:0], 1'b1};
      end else begin
        t.rem = r;
        t.lq  = {t.lq[Q_W-2:0], 1'b0};
      end
    end
    return t;
  endfunction

  logic [DIV_STAGES-1:0] v_q;
  dstage_t stg_q  [DIV_STAGES];
  dstage_t stg_in [DIV_STAGES];
  dstage_t seed;

  // Upper numerator bits seed the remainder; quotient overflows if they reach den
  assign seed.rem = R_W'(num_i[NUM_W-1:Q_W]);
  assign seed.lq  = num_i[Q_W-1:0];
  assign seed.den = den_i;
  assign seed.ovf = R_W'(num_i[NUM_W-1:Q_W]) >= R_W'(den_i);
  assign seed.tag = tag_i;

  assign stg_in[0] = seed;
  for (genvar s = 1; s < DIV_STAGES; s++) begin : g_link
    assign stg_in[s] = stg_q[s-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[DIV_STAGES-2:0], valid_i};
    end
  end

  // Each stage retires DIV_STEPS quotient bits
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        stg_q[s] <= div_step(stg_in[s]);
      end
    end
  end

  assign valid_o = v_q[DIV_STAGES-1];
  assign quot_o  = stg_q[DIV_STAGES-1].lq;
  assign ovf_o   = stg_q[DIV_STAGES-1].ovf;
  assign tag_o   = stg_q[DIV_STAGES-1].tag;

endmodule

/* design/p1_triangle_element_stiffness.sv */
`timescale 1ns / 1ps
// Top level of the P1 triangle element stiffness block: scale register, front end,
// entry sequencer, numerator path, divider and output register. Depends on p1t_pkg.
//
// Usage:
//   One input item on in_valid_i/in_ready_o carries a triangle (three node numbers,
//   three vertices, eps_relative). It yields nine result items on
//   out_valid_o/out_ready_i, the 3x3 element matrix in row-major order, the ninth
//   marked last_entry. entry_value = eps_rel * scale * (bi*bj+ci*cj) / (2|D|) in
//   Q.16, rounded half away from zero and saturated; a zero determinant gives zero
//   entries with degenerate set.
//   cfg_we_i/cfg_wdata_i write permittivity_scale (Q16.16); write it
//   only while the block is idle.
//   Path of the first entry: 3 front stages, the sequencer, 5 numerator stages,
//   12 divider stages, output register. The sequencer issues one entry per cycle
//   onto the single result channel while the receiver does not stall; the next
//   triangle is taken while the current one is still being issued.
//   Reset clears all valid bits and sets the scale to 1.0. When the receiver
//   stalls, the whole entry pipeline holds; the front end keeps taking items
//   until its three stages are full.
module p1_triangle_element_stiffness (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [p1t_pkg::SCALE_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  p1t_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output p1t_pkg::out_item_t          out_item_o
);
  import p1t_pkg::*;

  logic [SCALE_W-1:0] scale_q;
  logic      adv;
  logic      tri_valid, tri_ready;
  tri_t      tri_d;
  logic      job_valid;
  job_t      job;
  logic      num_valid;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  tag_t      num_tag, div_tag;
  logic      div_valid, div_ovf;
  logic [Q_W-1:0] quot;
  logic [Q_W-1:0] value;
  logic      out_valid_q;
  out_item_t out_item_q;

  // Scale register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  // Entry pipeline advances whenever the output register can take a new item
  assign adv = !out_valid_q || out_ready_i;

  p1t_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scale_i     (scale_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .tri_valid_o (tri_valid),
    .tri_ready_i (tri_ready),
    .tri_o       (tri_d)
  );

  p1t_expand u_expand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .tri_valid_i (tri_valid),
    .tri_ready_o (tri_ready),
    .tri_i       (tri_d),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  p1t_entry u_entry (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .job_valid_i (job_valid),
    .job_i       (job),
    .num_valid_o (num_valid),
    .num_o       (num),
    .den_o       (den),
    .tag_o       (num_tag)
  );

  p1t_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (num_valid),
    .num_i   (num),
    .den_i   (den),
    .tag_i   (num_tag),
    .valid_o (div_valid),
    .quot_o  (quot),
    .ovf_o   (div_ovf),
    .tag_o   (div_tag)
  );

  // Saturate and apply the sign; degenerate triangles give zero
  always_comb begin
    if (div_tag.degen) begin
      value = '0;
    end else if (!div_tag.neg) begin
      value = (div_ovf || quot > MAX_POS) ? MAX_POS : quot;
    end else if (div_ovf || quot > MAX_NEG) begin
      value = MAX_NEG;
    end else begin
      value = Q_W'(-quot);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q.row_node    <= div_tag.row;
      out_item_q.col_node    <= div_tag.col;
      out_item_q.entry_value <= signed'(value);
      out_item_q.degenerate  <= div_tag.degen;
      out_item_q.last_entry  <= div_tag.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // A degenerate triangle only ever produces zero entries
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.degenerate |-> out_item_o.entry_value == '0)
    else $error("degenerate entry is not zero");

  // While the output stalls, the divider pipeline holds
  a_div_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(div_valid) && $stable(quot))
    else $error("divider moved during stall");

  // While the output stalls, the sequencer issues nothing new
  a_seq_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(job_valid) && $stable(job.last))
    else $error("sequencer moved during stall");
`endif

endmodule
